// ===== rtl/ppsch_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file refers to this package by scoped names.
package ppsch_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int ID_W          = 4;
	localparam int ID_SLOTS      = 1 << ID_W;
	localparam int PRIO_W        = 8;
	localparam int BURST_W       = 12;
	localparam int TIME_W        = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic {
		CMD_ARRIVE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ACCEPT  = 3'd0,
		ST_PREEMPT = 3'd1,
		ST_FINISH  = 3'd2,
		ST_IDLE    = 3'd3,
		ST_REJECT  = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t               command;
		logic [ID_W-1:0]    task_id;
		logic [PRIO_W-1:0]  task_priority;
		logic [BURST_W-1:0] burst_length;
		logic [TIME_W-1:0]  arrival_stamp;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   served_task;
		logic [TIME_W-1:0] now_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_total;
	} result_t;

	// One ready-list entry as held in a cell.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_ARRIVE = 2'd1,
		OP_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     take_new;
		logic     take_head;
	} cell_ctl_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrival;
	} task_load_t;

endpackage

// ===== rtl/ppsch_cell.sv =====
// One slot of the ready list: holds a task id and its priority.
// Depends on ppsch_pkg for the entry and control types.
module ppsch_cell (
	input  logic                clk,
	input  ppsch_pkg::cell_ctl_t ctl,
	input  ppsch_pkg::entry_t   new_entry,
	input  ppsch_pkg::entry_t   head_entry,
	input  ppsch_pkg::entry_t   next_entry,
	output ppsch_pkg::entry_t   entry
);

	ppsch_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			ppsch_pkg::OP_ARRIVE: begin
				if (ctl.take_new) begin
					entry_q <= new_entry;
				end else if (entry_q.id == new_entry.id) begin
					// repeated id: the newest priority applies to every copy
					entry_q.prio <= new_entry.prio;
				end
			end
			ppsch_pkg::OP_SHIFT: begin
				if (ctl.take_new) begin
					entry_q <= new_entry;
				end else if (ctl.take_head) begin
					entry_q <= head_entry;
				end else begin
					entry_q <= next_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;

endmodule

// ===== rtl/ppsch_tasks.sv =====
// Per-task tables indexed by task id: remaining, burst and arrival time.
// Depends on ppsch_pkg; one read port, writes on arrival and after a run.
module ppsch_tasks (
	input  logic                               clk,
	input  logic                               load_en,
	input  ppsch_pkg::task_load_t              load,
	input  logic                               dec_en,
	input  logic [ppsch_pkg::ID_W-1:0]         rd_id,
	output logic [ppsch_pkg::BURST_W-1:0]      rem_left,
	output logic [ppsch_pkg::BURST_W-1:0]      burst,
	output logic [ppsch_pkg::TIME_W-1:0]       arrival
);

	logic [ppsch_pkg::BURST_W-1:0] remaining_q [ppsch_pkg::ID_SLOTS];
	logic [ppsch_pkg::BURST_W-1:0] burst_q     [ppsch_pkg::ID_SLOTS];
	logic [ppsch_pkg::TIME_W-1:0]  arrival_q   [ppsch_pkg::ID_SLOTS];
	logic [ppsch_pkg::BURST_W-1:0] rem_rd;

	assign rem_rd   = remaining_q[rd_id];
	assign rem_left = (rem_rd == '0) ? '0 : rem_rd - ppsch_pkg::BURST_W'(1);
	assign burst    = burst_q[rd_id];
	assign arrival  = arrival_q[rd_id];

	always_ff @(posedge clk) begin
		if (load_en) begin
			remaining_q[load.id] <= load.burst;
			burst_q[load.id]     <= load.burst;
			arrival_q[load.id]   <= load.arrival;
		end else if (dec_en) begin
			remaining_q[rd_id] <= rem_left;
		end
	end

endmodule

// ===== rtl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler with unit time slices. An arrival or an idle
// tick is handled at the accepting edge: its result appears in the cycle after
// start with busy staying low, so these commands can be issued every cycle.
// A tick with tasks ready raises busy and shows its result on the cycle busy
// falls; busy covers the scan, in which the ready list is rotated once through
// the chain of cells while the head entry is compared, then the list update
// and then the waiting-time subtract. done pulses for one cycle per result and
// cannot be held off.
module preemptive_priority_scheduler #(
	parameter int MAX_TASKS = ppsch_pkg::MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ppsch_pkg::item_t   item,
	output logic               done,
	output ppsch_pkg::result_t result
);

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int LW = $clog2(MAX_TASKS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic [CW-1:0]                  count_q;
	logic [ppsch_pkg::TIME_W-1:0]   time_q;
	logic [LW-1:0]                  scan_q;
	logic [LW-1:0]                  loc_q;
	logic [ppsch_pkg::ID_W-1:0]     pick_q;
	logic [ppsch_pkg::PRIO_W-1:0]   best_q;
	logic [ppsch_pkg::TIME_W-1:0]   tat_q;
	logic                           fin_q;
	logic                           done_q;
	ppsch_pkg::result_t             result_q;

	ppsch_pkg::entry_t              cell_entry [MAX_TASKS];
	ppsch_pkg::cell_ctl_t           cell_ctl   [MAX_TASKS];
	ppsch_pkg::entry_t              new_entry;
	ppsch_pkg::cell_op_t            op;

	logic                           accept;
	logic                           arrive_ok;
	logic                           full;
	logic [CW-1:0]                  last_slot;
	logic [ppsch_pkg::TIME_W-1:0]   time_inc;
	logic [ppsch_pkg::TIME_W-1:0]   time_arr;
	logic                           append;
	logic [ppsch_pkg::BURST_W-1:0]  rem_left;
	logic [ppsch_pkg::BURST_W-1:0]  burst_rd;
	logic [ppsch_pkg::TIME_W-1:0]   arrival_rd;
	logic [ppsch_pkg::TIME_W-1:0]   burst_ext;
	ppsch_pkg::task_load_t          load;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign full      = (count_q == CW'(MAX_TASKS));
	assign arrive_ok = accept && (item.command == ppsch_pkg::CMD_ARRIVE) && !full
		&& (item.burst_length != '0);
	assign last_slot = count_q - CW'(1);
	assign time_inc  = (time_q == ppsch_pkg::TIME_MAX) ? time_q
		: time_q + ppsch_pkg::TIME_W'(1);
	assign time_arr  = ((count_q == '0) && (item.arrival_stamp > time_q))
		? item.arrival_stamp : time_q;
	assign append    = (rem_left != '0);
	assign burst_ext = ppsch_pkg::TIME_W'(burst_rd);

	assign load.id      = item.task_id;
	assign load.burst   = item.burst_length;
	assign load.arrival = item.arrival_stamp;

	always_comb begin
		if (state_q == S_APPLY) begin
			new_entry.id   = pick_q;
			new_entry.prio = best_q;
		end else begin
			new_entry.id   = item.task_id;
			new_entry.prio = item.task_priority;
		end
		if (arrive_ok) begin
			op = ppsch_pkg::OP_ARRIVE;
		end else if (state_q == S_SCAN || state_q == S_APPLY) begin
			op = ppsch_pkg::OP_SHIFT;
		end else begin
			op = ppsch_pkg::OP_HOLD;
		end
	end

	ppsch_tasks u_tasks (
		.clk      (clk),
		.load_en  (arrive_ok),
		.load     (load),
		.dec_en   (state_q == S_APPLY),
		.rd_id    (pick_q),
		.rem_left (rem_left),
		.burst    (burst_rd),
		.arrival  (arrival_rd)
	);

	// Scan: rotate left, tail takes head. Apply: shift left, the slot before
	// the chosen one takes the head, the tail takes back a runner with time left.
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		ppsch_pkg::entry_t next_in;

		if (i == MAX_TASKS - 1) begin : g_end
			assign next_in = '0;
		end else begin : g_mid
			assign next_in = cell_entry[i+1];
		end

		assign cell_ctl[i].op = op;
		assign cell_ctl[i].take_new =
			(arrive_ok && CW'(i) == count_q)
			|| (state_q == S_APPLY && append && CW'(i) == last_slot);
		assign cell_ctl[i].take_head =
			(state_q == S_SCAN && CW'(i) == last_slot)
			|| (state_q == S_APPLY && CW'(i + 1) == CW'(loc_q));

		ppsch_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.new_entry  (new_entry),
			.head_entry (cell_entry[0]),
			.next_entry (next_in),
			.entry      (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			time_q   <= '0;
			done_q   <= 1'b0;
			scan_q   <= '0;
			loc_q    <= '0;
			pick_q   <= '0;
			best_q   <= '0;
			tat_q    <= '0;
			fin_q    <= 1'b0;
			result_q <= '0;
		end else begin
			// arrivals and idle ticks answer at once, long ticks from S_DONE
			done_q <= (state_q == S_DONE)
				|| (accept && (item.command == ppsch_pkg::CMD_ARRIVE || count_q == '0));
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (item.command == ppsch_pkg::CMD_ARRIVE) begin
							result_q.served_task <= item.task_id;
							result_q.turnaround  <= '0;
							result_q.wait_total  <= '0;
							if (arrive_ok) begin
								count_q          <= count_q + CW'(1);
								time_q           <= time_arr;
								result_q.status   <= ppsch_pkg::ST_ACCEPT;
								result_q.now_time <= time_arr;
							end else begin
								result_q.status   <= ppsch_pkg::ST_REJECT;
								result_q.now_time <= time_q;
							end
						end else if (count_q == '0) begin
							result_q.status      <= ppsch_pkg::ST_IDLE;
							result_q.served_task <= '0;
							result_q.now_time    <= time_q;
							result_q.turnaround  <= '0;
							result_q.wait_total  <= '0;
						end else begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// strict less-than keeps the entry nearest the head on a tie
					if (scan_q == '0 || cell_entry[0].prio < best_q) begin
						best_q <= cell_entry[0].prio;
						pick_q <= cell_entry[0].id;
						loc_q  <= scan_q;
					end
					scan_q <= scan_q + LW'(1);
					if (CW'(scan_q) == last_slot) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					time_q  <= time_inc;
					fin_q   <= !append;
					count_q <= append ? count_q : last_slot;
					tat_q   <= (!append && time_inc > arrival_rd)
						? time_inc - arrival_rd : '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					result_q.status      <= fin_q ? ppsch_pkg::ST_FINISH
						: ppsch_pkg::ST_PREEMPT;
					result_q.served_task <= pick_q;
					result_q.now_time    <= time_q;
					result_q.turnaround  <= tat_q;
					result_q.wait_total  <= (tat_q > burst_ext) ? tat_q - burst_ext : '0;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/ppsch_checker.sv =====
// Port-level checks for the preemptive priority scheduler, bound to the top.
// Depends on ppsch_pkg for the result type and status codes.
module ppsch_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input ppsch_pkg::result_t result
);

	// an accepted beat is answered next cycle or starts a long tick
	a_accept_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done != busy))
		else $error("accepted beat neither answered nor started a tick");

	// a long tick ends exactly when its result beat is shown
	a_busy_ends_with_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result beat");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ppsch_pkg::ST_IDLE) |->
		(result.served_task == '0 && result.turnaround == '0))
		else $error("idle beat carries task data");

	a_times_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ppsch_pkg::ST_FINISH) |->
		(result.turnaround == '0 && result.wait_total == '0))
		else $error("times reported on a beat that is not a finish");

	a_wait_within_turnaround: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ppsch_pkg::ST_FINISH) |->
		(result.wait_total <= result.turnaround))
		else $error("waiting time exceeds turnaround");

endmodule

bind preemptive_priority_scheduler ppsch_checker u_ppsch_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the preemptive priority scheduler.
// Needs ppsch_pkg and preemptive_priority_scheduler; drives command beats, checks results.
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_BEATS = 800;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	ppsch_pkg::item_t   item;
	logic               done;
	ppsch_pkg::result_t result;

	preemptive_priority_scheduler DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// scheduler image kept by the testbench
	logic [ppsch_pkg::ID_W-1:0]    run_queue [ppsch_pkg::MAX_TASKS_DEF];
	int                            run_count = 0;
	logic [ppsch_pkg::TIME_W-1:0]  sched_clock = '0;
	logic [ppsch_pkg::PRIO_W-1:0]  prio_of [ppsch_pkg::ID_SLOTS];
	logic [ppsch_pkg::BURST_W-1:0] left_of [ppsch_pkg::ID_SLOTS];
	logic [ppsch_pkg::BURST_W-1:0] burst_of [ppsch_pkg::ID_SLOTS];
	logic [ppsch_pkg::TIME_W-1:0]  arrived_of [ppsch_pkg::ID_SLOTS];

	ppsch_pkg::result_t outcomes_due [$];
	int                 errors = 0;
	int                 beats_sent = 0;
	int                 idle_pct = 0;
	int                 cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Applies one beat to the scheduler image and returns the result it should give.
	function automatic ppsch_pkg::result_t schedule(input ppsch_pkg::item_t it);
		ppsch_pkg::result_t           r;
		int                           i;
		int                           loc;
		logic [ppsch_pkg::ID_W-1:0]   pick;
		logic [ppsch_pkg::TIME_W-1:0] tat;
		r = '0;
		if (it.command == ppsch_pkg::CMD_ARRIVE) begin
			r.served_task = it.task_id;
			if (run_count >= ppsch_pkg::MAX_TASKS_DEF || it.burst_length == '0) begin
				r.status = ppsch_pkg::ST_REJECT;
			end else begin
				prio_of[it.task_id]    = it.task_priority;
				burst_of[it.task_id]   = it.burst_length;
				left_of[it.task_id]    = it.burst_length;
				arrived_of[it.task_id] = it.arrival_stamp;
				if (run_count == 0 && it.arrival_stamp > sched_clock)
					sched_clock = it.arrival_stamp;
				run_queue[run_count] = it.task_id;
				run_count++;
				r.status = ppsch_pkg::ST_ACCEPT;
			end
		end else if (run_count == 0) begin
			r.status = ppsch_pkg::ST_IDLE;
		end else begin
			loc  = 0;
			pick = run_queue[0];
			// strict compare: on a tie the entry nearest the head keeps the slot
			for (i = 1; i < run_count; i++) begin
				if (prio_of[run_queue[i]] < prio_of[pick]) begin
					pick = run_queue[i];
					loc  = i;
				end
			end
			run_queue[loc] = run_queue[0];
			for (i = 1; i < run_count; i++)
				run_queue[i-1] = run_queue[i];
			run_count--;
			if (sched_clock != ppsch_pkg::TIME_MAX)
				sched_clock++;
			if (left_of[pick] != '0)
				left_of[pick]--;
			r.served_task = pick;
			if (left_of[pick] != '0) begin
				run_queue[run_count] = pick;
				run_count++;
				r.status = ppsch_pkg::ST_PREEMPT;
			end else begin
				tat = (sched_clock > arrived_of[pick]) ? sched_clock - arrived_of[pick] : '0;
				r.status     = ppsch_pkg::ST_FINISH;
				r.turnaround = tat;
				r.wait_total = (tat > burst_of[pick]) ? tat - burst_of[pick] : '0;
			end
		end
		r.now_time = sched_clock;
		return r;
	endfunction

	function automatic void flag(input string field, input logic [15:0] want,
			input logic [15:0] got);
		$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		errors++;
	endfunction

	task automatic check_outcome(input ppsch_pkg::result_t got);
		ppsch_pkg::result_t want;
		if (outcomes_due.size() == 0) begin
			$display("%0t: result with nothing outstanding, expected none, got %p", $time, got);
			errors++;
		end else begin
			want = outcomes_due.pop_front();
			if (got.status !== want.status)
				flag("status", 16'(want.status), 16'(got.status));
			if (got.served_task !== want.served_task)
				flag("served_task", 16'(want.served_task), 16'(got.served_task));
			if (got.now_time !== want.now_time)
				flag("now_time", want.now_time, got.now_time);
			if (got.turnaround !== want.turnaround)
				flag("turnaround", want.turnaround, got.turnaround);
			if (got.wait_total !== want.wait_total)
				flag("wait_total", want.wait_total, got.wait_total);
		end
	endtask

	// check before predicting: a beat's result never shows on its own accepting edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				check_outcome(result);
			if (start && !busy)
				outcomes_due.push_back(schedule(item));
		end
	end

	// Called and returns just after a falling edge; start stays up for a back-to-back beat.
	task automatic send_item(input ppsch_pkg::item_t it);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		item  = it;
		do @(posedge clk); while (busy);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic arrive(input int id, input int prio, input int burst, input int stamp);
		ppsch_pkg::item_t it;
		it.command       = ppsch_pkg::CMD_ARRIVE;
		it.task_id       = ppsch_pkg::ID_W'(id);
		it.task_priority = ppsch_pkg::PRIO_W'(prio);
		it.burst_length  = ppsch_pkg::BURST_W'(burst);
		it.arrival_stamp = ppsch_pkg::TIME_W'(stamp);
		send_item(it);
	endtask

	// unused payload bits of a tick carry noise
	task automatic tick();
		ppsch_pkg::item_t it;
		logic [63:0]      noise;
		noise = {$urandom, $urandom};
		it = noise[$bits(ppsch_pkg::item_t)-1:0];
		it.command = ppsch_pkg::CMD_TICK;
		send_item(it);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (outcomes_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_idle_and_reject();
		tick();
		arrive(0, 0, 0, 0);
	endtask

	task automatic test_priority_order();
		arrive(3, 10, 2, 100);
		arrive(5, 10, 1, 100);
		arrive(7, 2, 1, 500);   // stamp later than its finish
		repeat (5) tick();
	endtask

	task automatic test_repeated_id();
		arrive(9, 1, 1, 0);
		arrive(9, 0, 2, 0);
		repeat (3) tick();
	endtask

	task automatic test_short_turnaround();
		int t0;
		t0 = sched_clock;
		arrive(1, 255, 3, t0);
		arrive(2, 0, 2, t0 + 1);
		repeat (5) tick();
	endtask

	task automatic random_arrival();
		int id, prio, burst, stamp, pick;
		id   = $urandom_range(0, 15);
		prio = $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
		pick = $urandom_range(99);
		burst = (pick < 5) ? 0 : (pick < 95) ? $urandom_range(1, 6) : $urandom_range(7, 40);
		pick = $urandom_range(99);
		if (run_count == 0) begin
			// earlier stamps are allowed too; they just do not move the clock
			stamp = (pick < 10 && sched_clock > 8) ? sched_clock - $urandom_range(1, 8)
				: sched_clock + $urandom_range(0, 40);
		end else begin
			stamp = (pick < 10) ? $urandom_range(0, 65535) : sched_clock + $urandom_range(0, 2);
		end
		if (stamp > 65535)
			stamp = 65535;
		arrive(id, prio, burst, stamp);
	endtask

	task automatic random_episode(input bit fill);
		int n, k, budget;
		n = (fill || $urandom_range(9) == 0) ? ppsch_pkg::MAX_TASKS_DEF + 2
			: $urandom_range(1, 5);
		for (k = 0; k < n; k++) begin
			random_arrival();
			if ($urandom_range(99) < 30)
				tick();
		end
		// now and then leave work behind for the next episode
		budget = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 400;
		while (run_count > 0 && budget > 0) begin
			tick();
			budget--;
		end
		repeat ($urandom_range(0, 2)) tick();
	endtask

	task automatic test_random(input int pct, input int goal);
		bit first;
		idle_pct = pct;
		first = 1'b1;
		while (beats_sent < goal) begin
			random_episode(first);
			first = 1'b0;
		end
		idle_pct = 0;
		wait_drained();
	endtask

	// last on purpose: once the clock saturates it never moves again
	task automatic test_time_limit();
		while (run_count > 0)
			tick();
		arrive(15, 255, 4095, 65535);
		tick();
		arrive(0, 0, 1, 65535);
		repeat (2) tick();
	endtask

	initial begin
		int base;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_and_reject();
		test_priority_order();
		test_repeated_id();
		test_short_turnaround();
		wait_drained();

		base = beats_sent;
		test_random(0, base + RANDOM_BEATS / 3);
		test_random(70, base + 2 * RANDOM_BEATS / 3);
		test_random(36, base + RANDOM_BEATS);

		test_time_limit();
		wait_drained();
		// catch stray strobes after the last result
		repeat (25) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
